@@ src/kpd_pkg.sv @@
// ----------------------------------------------------------------------------
// kpd_pkg
// Shared types, register codes and reset values for the ladder keypad block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kpd_pkg;

  // Number of keys decoded from the ladder (1 to 4); output masks stay 4 bits.
  localparam int NUM_KEYS = 4;
  localparam int KEY_W    = 4;

  localparam int MV_W     = 12;
  localparam int HALF_W   = 10;
  localparam int MS_W     = 16;
  localparam int TIME_W   = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG    = 3'd6;

  // Reset values of the configuration registers
  localparam logic [MV_W-1:0]   RST_CENTER0 = 12'd2200;
  localparam logic [MV_W-1:0]   RST_CENTER1 = 12'd2870;
  localparam logic [MV_W-1:0]   RST_CENTER2 = 12'd3300;
  localparam logic [MV_W-1:0]   RST_CENTER3 = 12'd1320;
  localparam logic [HALF_W-1:0] RST_HALF    = 10'd200;
  localparam logic [MS_W-1:0]   RST_SETTLE  = 16'd40;
  localparam logic [MS_W-1:0]   RST_LONG    = 16'd1000;

  typedef logic [KEY_W-1:0][MV_W-1:0] center_arr_t;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_PRESSED = 2'd1,
    PH_WAIT    = 2'd2
  } phase_t;

  typedef struct packed {
    logic [MV_W-1:0]   sample_mv;
    logic [TIME_W-1:0] now_ms;
  } kpd_in_t;

  typedef struct packed {
    logic [KEY_W-1:0] short_press;
    logic [KEY_W-1:0] long_press;
    logic [KEY_W-1:0] keys_down;
  } kpd_out_t;

  // Debounce result handed to the per-key press machines
  typedef struct packed {
    logic [KEY_W-1:0] edges;
    logic [KEY_W-1:0] down;
  } kpd_evt_t;

endpackage

`default_nettype wire

@@ src/ladder_keypad_debounce_long_press.sv @@
// ----------------------------------------------------------------------------
// ladder_keypad_debounce_long_press
// Resistor-ladder keypad decoder with debounce and short/long press reports.
// ----------------------------------------------------------------------------
// Pipeline: a transferred sample passes two register stages (input register,
//   result register) on its way to out_; out_stall can hold it in the first.
// Throughput: one sample per cycle while out_stall does not hold the result
//   register; the window match, debounce and key machines sit between the two.
// Reset (synchronous, rst_n low): registers return to their defaults, the
//   debounce state and all key machines clear, both stages empty.
`timescale 1ns / 1ps
`default_nettype none

module ladder_keypad_debounce_long_press (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire kpd_pkg::kpd_in_t                  in_data,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output kpd_pkg::kpd_out_t                      out_data,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [kpd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [kpd_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import kpd_pkg::*;

  // configuration registers
  center_arr_t       center_r;
  logic [HALF_W-1:0] half_r;
  logic [MS_W-1:0]   settle_r;
  logic [MS_W-1:0]   long_r;

  // pipeline
  logic     s1_valid_r;
  kpd_in_t  s1_data_r;
  logic     out_valid_r;
  kpd_out_t out_data_r;
  logic     in_xfer;
  logic     advance;

  logic [KEY_W-1:0] pattern;
  kpd_evt_t         evt;
  logic [KEY_W-1:0] shorts;
  logic [KEY_W-1:0] longs;
  kpd_out_t         result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_r[0] <= RST_CENTER0;
      center_r[1] <= RST_CENTER1;
      center_r[2] <= RST_CENTER2;
      center_r[3] <= RST_CENTER3;
      half_r      <= RST_HALF;
      settle_r    <= RST_SETTLE;
      long_r      <= RST_LONG;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index) inside
        CFG_CENTER0, CFG_CENTER1, CFG_CENTER2, CFG_CENTER3: begin
          center_r[cfg_index[1:0]] <= cfg_data[MV_W-1:0];
        end
        CFG_HALF:   half_r   <= cfg_data[HALF_W-1:0];
        CFG_SETTLE: settle_r <= cfg_data[MS_W-1:0];
        CFG_LONG:   long_r   <= cfg_data[MS_W-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // advance when the result register is free or being drained
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign in_xfer  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) s1_data_r <= in_data;
  end

  kpd_window u_window (
    .sample_mv (s1_data_r.sample_mv),
    .centers   (center_r),
    .half_mv   (half_r),
    .pattern   (pattern)
  );

  kpd_debounce u_debounce (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .pattern   (pattern),
    .now_ms    (s1_data_r.now_ms),
    .settle_ms (settle_r),
    .evt       (evt)
  );

  for (genvar k = 0; k < KEY_W; k++) begin : g_key
    if (k < NUM_KEYS) begin : g_on
      kpd_key_fsm u_key (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .edge_hit  (evt.edges[k]),
        .down      (evt.down[k]),
        .now_ms    (s1_data_r.now_ms),
        .long_ms   (long_r),
        .short_hit (shorts[k]),
        .long_hit  (longs[k])
      );
    end else begin : g_off
      assign shorts[k] = 1'b0;
      assign longs[k]  = 1'b0;
    end
  end

  assign result.short_press = shorts;
  assign result.long_press  = longs;
  assign result.keys_down   = evt.down;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_data_r <= result;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ------------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------------
  a_no_short_and_long: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.short_press & out_data.long_press) == '0))
    else $error("key reports short and long press in one result");

  a_short_on_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.short_press & out_data.keys_down) == '0))
    else $error("short press reported while key still down");

  a_long_while_down: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.long_press & ~out_data.keys_down) == '0))
    else $error("long press reported for a released key");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> !in_stall)
    else $error("input stalled with empty input register");

endmodule

`default_nettype wire

@@ src/kpd_window.sv @@
// ----------------------------------------------------------------------------
// kpd_window
// Matches one line sample against the key voltage windows, lowest key first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kpd_window (
  input  wire logic [kpd_pkg::MV_W-1:0]   sample_mv,
  input  wire kpd_pkg::center_arr_t       centers,
  input  wire logic [kpd_pkg::HALF_W-1:0] half_mv,
  output logic      [kpd_pkg::KEY_W-1:0]  pattern
);
  import kpd_pkg::*;

  logic [MV_W:0] s_plus_h;
  logic [KEY_W-1:0] hit;

  assign s_plus_h = {1'b0, sample_mv} + {{(MV_W+1-HALF_W){1'b0}}, half_mv};

  // c - h < s < c + h, rewritten as s + h > c and s < c + h
  always_comb begin
    logic [MV_W:0] c_plus_h;
    hit = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      c_plus_h = {1'b0, centers[k]} + {{(MV_W+1-HALF_W){1'b0}}, half_mv};
      hit[k] = (s_plus_h > {1'b0, centers[k]}) && ({1'b0, sample_mv} < c_plus_h);
    end
  end

  // lowest numbered key wins on overlap
  always_comb begin
    pattern = '0;
    for (int k = NUM_KEYS - 1; k >= 0; k--) begin
      if (hit[k]) begin
        pattern    = '0;
        pattern[k] = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ src/kpd_debounce.sv @@
// ----------------------------------------------------------------------------
// kpd_debounce
// Holds the candidate key pattern and promotes it once it has settled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kpd_debounce (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        step,
  input  wire logic [kpd_pkg::KEY_W-1:0]   pattern,
  input  wire logic [kpd_pkg::TIME_W-1:0]  now_ms,
  input  wire logic [kpd_pkg::MS_W-1:0]    settle_ms,
  output kpd_pkg::kpd_evt_t                evt
);
  import kpd_pkg::*;

  logic [KEY_W-1:0]  cand_r, cand_nxt;
  logic [TIME_W-1:0] since_r, since_nxt;
  logic [KEY_W-1:0]  deb_r, deb_nxt;
  logic [TIME_W-1:0] held;
  logic [KEY_W-1:0]  edges;

  assign held = now_ms - since_r;

  always_comb begin
    cand_nxt  = cand_r;
    since_nxt = since_r;
    deb_nxt   = deb_r;
    edges     = '0;
    if (pattern != cand_r) begin
      // restart the settle timer on any change
      cand_nxt  = pattern;
      since_nxt = now_ms;
    end else if (held >= {{(TIME_W-MS_W){1'b0}}, settle_ms}) begin
      edges   = cand_r ^ deb_r;
      deb_nxt = cand_r;
    end
  end

  assign evt.edges = edges;
  assign evt.down  = deb_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_r  <= '0;
      since_r <= '0;
      deb_r   <= '0;
    end else if (step) begin
      cand_r  <= cand_nxt;
      since_r <= since_nxt;
      deb_r   <= deb_nxt;
    end
  end

endmodule

`default_nettype wire

@@ src/kpd_key_fsm.sv @@
// ----------------------------------------------------------------------------
// kpd_key_fsm
// Press machine of one key: idle, pressed, wait for release.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kpd_key_fsm (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        step,
  input  wire logic                        edge_hit,
  input  wire logic                        down,
  input  wire logic [kpd_pkg::TIME_W-1:0]  now_ms,
  input  wire logic [kpd_pkg::MS_W-1:0]    long_ms,
  output logic                             short_hit,
  output logic                             long_hit
);
  import kpd_pkg::*;

  phase_t            phase_r, phase_nxt;
  phase_t            phase_mid;
  logic [TIME_W-1:0] start_r, start_nxt;
  logic [TIME_W-1:0] elapsed;
  logic              load;
  logic              release_short;
  logic              long_due;

  assign elapsed = now_ms - start_r;

  // phase after the edge event, before the long press check
  always_comb begin
    phase_mid     = phase_r;
    load          = 1'b0;
    release_short = 1'b0;
    if (edge_hit) begin
      unique case (phase_r)
        PH_PRESSED: begin
          if (!down) begin
            release_short = 1'b1;
            phase_mid     = PH_IDLE;
          end
        end
        PH_WAIT: begin
          if (!down) phase_mid = PH_IDLE;
        end
        default: begin
          if (down) begin
            load      = 1'b1;
            phase_mid = PH_PRESSED;
          end else begin
            phase_mid = PH_IDLE;
          end
        end
      endcase
    end
  end

  // a fresh press has zero elapsed time
  assign long_due = (phase_mid == PH_PRESSED) &&
                    (load ? (long_ms == '0)
                          : (elapsed >= {{(TIME_W-MS_W){1'b0}}, long_ms}));

  // next state
  always_comb begin
    phase_nxt = long_due ? PH_WAIT : phase_mid;
    start_nxt = load ? now_ms : start_r;
  end

  // outputs
  always_comb begin
    short_hit = release_short;
    long_hit  = long_due;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      start_r <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      start_r <= start_nxt;
    end
  end

endmodule

`default_nettype wire
